[hdl/hds_pkg.sv]
package hds_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
    localparam int SIZE_W  = 11;
    localparam int TEMP_W  = 16;
    localparam int SUM_W   = TEMP_W + 2;
    localparam int CFG_W   = SIZE_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

    localparam logic [SIZE_W-1:0] GRID_WIDTH_RESET  = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] GRID_HEIGHT_RESET = SIZE_W'(64);

    localparam logic [TEMP_W-1:0] TEMP_ZERO = '0;
    localparam logic [TEMP_W-1:0] TEMP_ONE  = TEMP_W'(32768);

    // Write side of the line buffers: one column per cell transfer.
    typedef struct packed {
        logic              en;
        logic [COL_W-1:0]  addr;
        logic [TEMP_W-1:0] two_data;
        logic [TEMP_W-1:0] one_data;
        logic              src_data;
    } lb_wr_t;

    // Registered read side, prefetched for the column of the next cell.
    typedef struct packed {
        logic [TEMP_W-1:0] two_x;
        logic [TEMP_W-1:0] one_x;
        logic [TEMP_W-1:0] one_x1;
        logic              src_x;
    } lb_rd_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] max_v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > max_v) begin
            r = max_v;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[hdl/hds_channels.sv]
interface hds_cell_if;
    logic                          valid;
    logic                          ready;
    logic [hds_pkg::TEMP_W-1:0]    cell_temperature;
    logic                          heat_source;
    logic                          flush;

    modport source (output valid, output cell_temperature, output heat_source,
                    output flush, input ready);
    modport sink   (input valid, input cell_temperature, input heat_source,
                    input flush, output ready);
endinterface

interface hds_result_if;
    logic                          valid;
    logic                          ready;
    logic [hds_pkg::TEMP_W-1:0]    new_temperature;
    logic                          last_cell;

    modport source (output valid, output new_temperature, output last_cell, input ready);
    modport sink   (input valid, input new_temperature, input last_cell, output ready);
endinterface

[hdl/hds_line_buffer.sv]
// Two row buffers and the source-flag buffer. Reads are registered and see a
// write to the same column in the same cycle, so data are always current.
module hds_line_buffer (
    input  logic                      clk,
    input  hds_pkg::lb_wr_t           wr,
    input  logic [hds_pkg::COL_W-1:0] rd_addr,
    output hds_pkg::lb_rd_t           rd
);

    logic [hds_pkg::TEMP_W-1:0] two_mem [hds_pkg::MAX_WIDTH];
    logic [hds_pkg::TEMP_W-1:0] one_mem [hds_pkg::MAX_WIDTH];
    logic                       src_mem [hds_pkg::MAX_WIDTH];

    logic [hds_pkg::COL_W-1:0]  rd_addr1;
    hds_pkg::lb_rd_t            rd_reg;

    assign rd_addr1 = rd_addr + hds_pkg::COL_W'(1);
    assign rd       = rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            two_mem[wr.addr] <= wr.two_data;
            one_mem[wr.addr] <= wr.one_data;
            src_mem[wr.addr] <= wr.src_data;
        end

        if (wr.en && wr.addr == rd_addr)
        begin
            rd_reg.two_x <= wr.two_data;
            rd_reg.one_x <= wr.one_data;
            rd_reg.src_x <= wr.src_data;
        end
        else
        begin
            rd_reg.two_x <= two_mem[rd_addr];
            rd_reg.one_x <= one_mem[rd_addr];
            rd_reg.src_x <= src_mem[rd_addr];
        end

        if (wr.en && wr.addr == rd_addr1)
        begin
            rd_reg.one_x1 <= wr.one_data;
        end
        else
        begin
            rd_reg.one_x1 <= one_mem[rd_addr1];
        end
    end

endmodule

[hdl/heat_diffusion_stencil_step_unit.sv]
// The result for a cell enters the output register with the transfer of the
// cell directly below it. Throughput: one cell per cycle while the result side
// is not stalled, set by the line-buffer read ports, which are always
// prefetched for the column of the next cell.
// Reset: rst_n clears the counters, the output valid and restores both sizes to 64;
// the row buffers keep whatever they hold and need no clearing.
module heat_diffusion_stencil_step_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [hds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hds_pkg::CFG_W-1:0]     cfg_data,
    hds_cell_if.sink                      cells,
    hds_result_if.source                  results
);

    // Configuration registers, kept raw and clamped where they are used.
    logic [hds_pkg::SIZE_W-1:0] width_reg,  width_next;
    logic [hds_pkg::SIZE_W-1:0] height_reg, height_next;

    // Raster position of the next grid cell. During the flush row the column
    // counter walks the drain items while the row counter sits at the height.
    logic [hds_pkg::COL_W-1:0]  col_reg, col_next;
    logic [hds_pkg::ROW_W-1:0]  row_reg, row_next;

    // Row-two-back value of the previous column. The previous cell copied its
    // row-one-back entry into the older buffer, so this is the left neighbour.
    logic [hds_pkg::TEMP_W-1:0] left_reg, left_next;

    // Output register: it parts the input side from the result side.
    logic                       out_valid_reg, out_valid_next;
    logic [hds_pkg::TEMP_W-1:0] out_temp_reg,  out_temp_next;
    logic                       out_last_reg,  out_last_next;

    logic [hds_pkg::SIZE_W-1:0] w_lim;
    logic [hds_pkg::SIZE_W-1:0] h_lim;
    logic                       at_row_end;
    logic                       grid_phase;
    logic                       in_fire;
    logic                       take_cell;
    logic                       take_flush;
    logic                       emit;
    logic                       border;
    logic [hds_pkg::SUM_W-1:0]  sum;
    logic [hds_pkg::TEMP_W-1:0] cell_value;

    hds_pkg::lb_wr_t            lb_wr;
    hds_pkg::lb_rd_t            lb_rd;

    hds_line_buffer u_line_buffer (
        .clk     (clk),
        .wr      (lb_wr),
        .rd_addr (col_next),
        .rd      (lb_rd)
    );

    // A new cell is taken whenever the output register is empty or is being emptied in
    // the same cycle, so a waiting result blocks the input only while results stall.
    assign cells.ready     = !out_valid_reg || results.ready;
    assign in_fire         = cells.valid && cells.ready;

    assign results.valid           = out_valid_reg;
    assign results.new_temperature = out_temp_reg;
    assign results.last_cell       = out_last_reg;

    assign w_lim      = hds_pkg::clamp_size(width_reg,
                                            hds_pkg::SIZE_W'(hds_pkg::MAX_WIDTH));
    assign h_lim      = hds_pkg::clamp_size(height_reg,
                                            hds_pkg::SIZE_W'(hds_pkg::MAX_HEIGHT));
    assign at_row_end = {1'b0, col_reg} >= (w_lim - hds_pkg::SIZE_W'(1));
    assign grid_phase = hds_pkg::SIZE_W'(row_reg) < h_lim;

    // A flush item during the grid and a grid cell after it are both taken
    // and dropped without any effect.
    assign take_cell  = in_fire && !cells.flush && grid_phase;
    assign take_flush = in_fire && cells.flush && !grid_phase;

    // The first row only fills the buffers. The bottom border row is never
    // computed here: it leaves as zeros during the flush row.
    assign emit   = take_flush || (take_cell && row_reg != '0);
    assign border = (col_reg == '0) || (row_reg == hds_pkg::ROW_W'(1)) || at_row_end;

    // Up, left and right come from the buffers, down is the cell now arriving.
    assign sum = hds_pkg::SUM_W'(lb_rd.two_x) + hds_pkg::SUM_W'(left_reg)
               + hds_pkg::SUM_W'(lb_rd.one_x1) + hds_pkg::SUM_W'(cells.cell_temperature);

    always_comb
    begin
        if (border)
        begin
            cell_value = hds_pkg::TEMP_ZERO;
        end
        else if (lb_rd.src_x)
        begin
            cell_value = hds_pkg::TEMP_ONE;
        end
        else
        begin
            cell_value = sum[hds_pkg::SUM_W-1:2];
        end
    end

    // Shift the column down one row and store the new cell.
    always_comb
    begin
        lb_wr.en       = take_cell;
        lb_wr.addr     = col_reg;
        lb_wr.two_data = lb_rd.one_x;
        lb_wr.one_data = cells.cell_temperature;
        lb_wr.src_data = cells.heat_source;
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                hds_pkg::REG_GRID_WIDTH:  width_next  = cfg_data;
                hds_pkg::REG_GRID_HEIGHT: height_next = cfg_data;
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (take_cell)
        begin
            left_next = lb_rd.one_x;
            if (at_row_end)
            begin
                col_next = '0;
                row_next = row_reg + hds_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + hds_pkg::COL_W'(1);
            end
        end
        else if (take_flush)
        begin
            if (at_row_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else
            begin
                col_next = col_reg + hds_pkg::COL_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_temp_next  = out_temp_reg;
        out_last_next  = out_last_reg;
        if (in_fire)
        begin
            out_valid_next = emit;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_temp_next = take_flush ? hds_pkg::TEMP_ZERO : cell_value;
            out_last_next = take_flush && at_row_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= hds_pkg::GRID_WIDTH_RESET;
            height_reg    <= hds_pkg::GRID_HEIGHT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg     <= left_next;
        out_temp_reg <= out_temp_next;
        out_last_reg <= out_last_next;
    end

    // The last drain item must leave both counters ready for the next grid.
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (take_flush && at_row_end) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters not cleared after the last flush item");

    // A result can only appear in the output register through a cell transfer.
    a_result_from_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_fire))
        else $error("result appeared without an input transfer");

    // The row counter never runs past the largest grid.
    a_row_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        hds_pkg::SIZE_W'(row_reg) <= hds_pkg::SIZE_W'(hds_pkg::MAX_HEIGHT))
        else $error("row counter beyond the largest grid");

    // The final cell lies on the border, so its value is always zero.
    a_last_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_temp_reg == hds_pkg::TEMP_ZERO))
        else $error("last cell carries a non-zero temperature");

endmodule

[dv/tb_heat_diffusion_stencil_step_unit.sv]
`timescale 1ns / 1ps

module tb_heat_diffusion_stencil_step_unit;

    import hds_pkg::*;

    // The two spare register indexes have no register behind them; writes to
    // them must leave both grid sizes untouched.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    // The slowest correct run is about 1150 cells, each waiting out the longest
    // sender gap and the longest result stall, plus a few pauses of up to one
    // full row; the limit is several times that.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 1030;
    localparam int unsigned REPORT_LIMIT = 10;

    // Hand-picked 4 x 4 grid. It holds the largest temperatures, values above
    // 1.0, source cells in the interior and on the border, and an interior cell
    // whose four neighbours are all 0xFFFF, so the truncated mean is 0xFFFF.
    localparam logic [0:15][TEMP_W-1:0] DEMO_TEMP = {
        16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000,
        16'h8000, 16'hFFFF, 16'hFFFF, 16'h0000,
        16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF,
        16'h0001, 16'hFFFF, 16'hFFFF, 16'h0000
    };
    localparam logic [0:15] DEMO_SOURCE = 16'b0000_1010_0100_0000;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              source;
        logic              flush;
    } cell_t;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              is_last;
    } result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    hds_cell_if   cell_ch ();
    hds_result_if result_ch ();

    heat_diffusion_stencil_step_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cells     (cell_ch),
        .results   (result_ch)
    );

    // Cells waiting to be driven, and the results the stencil predictor has
    // worked out but the block has not yet delivered.
    cell_t   cell_queue[$];
    result_t due_results[$];
    result_t head_result;

    // Predictor state: the two previous rows of temperatures, the source flags
    // of the newer row, the raster position and the raw size registers.
    logic [TEMP_W-1:0] older_line [MAX_WIDTH];
    logic [TEMP_W-1:0] newer_line [MAX_WIDTH];
    logic              newer_source [MAX_WIDTH];
    int unsigned       col_pos;
    int unsigned       row_pos;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    // When set, neither side idles, giving stretches of back-to-back transfers.
    bit          calm;
    int unsigned send_gap;
    int unsigned stall_left;

    int unsigned failures;
    int unsigned cells_taken;
    int unsigned results_seen;
    int unsigned grids_seen;
    int unsigned settings_used;
    int unsigned stimulus_items;
    int unsigned widest;
    int unsigned cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Size actually used by the block: a zero register means one, and anything
    // beyond the buffer depth is held at the buffer depth.
    function automatic int unsigned size_used(input logic [SIZE_W-1:0] raw,
                                              input int unsigned limit);
        if (raw == '0)
            return 1;
        if (raw > limit)
            return limit;
        return int'(raw);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, 2);
        if (roll < 95)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // Works out what the block must produce for one accepted cell and moves the
    // stencil state on. A cell in row y delivers the new value of the cell
    // above it, so the first grid row produces nothing.
    function automatic void diffuse_step(input cell_t c);
        int unsigned       w;
        int unsigned       h;
        int unsigned       x;
        int unsigned       r;
        logic              at_end;
        logic [SUM_W-1:0]  total;
        result_t           res;
        w      = size_used(width_reg, MAX_WIDTH);
        h      = size_used(height_reg, MAX_HEIGHT);
        x      = col_pos;
        at_end = (x >= w - 1);
        if (c.flush)
        begin
            // A flush transfer during the grid is dropped without a trace.
            if (row_pos < h)
                return;
            // The drained last row lies on the border, so it is all zero.
            res.temp    = TEMP_ZERO;
            res.is_last = at_end;
            due_results.push_back(res);
            if (at_end)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            else
                col_pos = x + 1;
            return;
        end
        // Once every row is in, grid cells are dropped until the flush row ends.
        if (row_pos >= h || x >= MAX_WIDTH)
            return;
        if (row_pos >= 1)
        begin
            r = row_pos - 1;
            if (x == 0 || r == 0 || at_end || r >= h - 1)
                res.temp = TEMP_ZERO;
            else if (newer_source[x])
                res.temp = TEMP_ONE;
            else
            begin
                // Above and to the left sit in the older line (the left one has
                // already been shifted across), to the right in the newer line,
                // and below is the arriving cell itself.
                total = SUM_W'(older_line[x]) + SUM_W'(older_line[x - 1])
                      + SUM_W'(newer_line[x + 1]) + SUM_W'(c.temp);
                res.temp = total[SUM_W-1:2];
            end
            res.is_last = 1'b0;
            due_results.push_back(res);
        end
        older_line[x]   = newer_line[x];
        newer_line[x]   = c.temp;
        newer_source[x] = c.source;
        if (at_end)
        begin
            col_pos = 0;
            row_pos = row_pos + 1;
        end
        else
            col_pos = x + 1;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    // Sender: a new cell is put on the channel only when the previous one has
    // been taken or none is waiting, so valid never drops before a transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_ch.valid            <= 1'b0;
            cell_ch.cell_temperature <= '0;
            cell_ch.heat_source      <= 1'b0;
            cell_ch.flush            <= 1'b0;
            send_gap                 <= 0;
        end
        else if (!cell_ch.valid || cell_ch.ready)
        begin
            if (send_gap != 0)
            begin
                cell_ch.valid <= 1'b0;
                send_gap      <= send_gap - 1;
            end
            else if (cell_queue.size() != 0)
            begin
                cell_ch.valid            <= 1'b1;
                cell_ch.cell_temperature <= cell_queue[0].temp;
                cell_ch.heat_source      <= cell_queue[0].source;
                cell_ch.flush            <= cell_queue[0].flush;
                cell_queue.pop_front();
                if (!calm && $urandom_range(0, 3) == 0)
                    send_gap <= pick_gap();
            end
            else
                cell_ch.valid <= 1'b0;
        end
    end

    // Receiver: ready is withdrawn now and then for a random stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
        end
        else if (stall_left != 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0)
                stall_left <= pick_gap();
        end
    end

    // Monitor: every result transfer is checked against the oldest prediction,
    // and every cell transfer is fed to the predictor. A result can never stem
    // from a cell taken at the same edge, so the order here is immaterial.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (due_results.size() == 0)
                    note_failure($sformatf(
                        "Unexpected result: temperature %0d, last_cell %0b",
                        result_ch.new_temperature, result_ch.last_cell));
                else
                begin
                    head_result = due_results.pop_front();
                    if (result_ch.new_temperature !== head_result.temp ||
                        result_ch.last_cell !== head_result.is_last)
                        note_failure($sformatf(
                            "Result %0d: expected temperature %0d last_cell %0b, got %0d %0b",
                            results_seen, head_result.temp, head_result.is_last,
                            result_ch.new_temperature, result_ch.last_cell));
                    if (head_result.is_last)
                        grids_seen++;
                end
            end
            if (cell_ch.valid && cell_ch.ready)
            begin
                cells_taken++;
                diffuse_step(cell_t'{temp: cell_ch.cell_temperature,
                                     source: cell_ch.heat_source,
                                     flush: cell_ch.flush});
            end
        end
    end

    initial
    begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("Run stopped after %0d cycles with %0d results outstanding",
                 cycle_count, due_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // A register write takes effect on the block at the next edge; nothing is
    // in flight then, so the predictor copy can follow at once.
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_GRID_WIDTH)
            width_reg = data;
        else if (idx == REG_GRID_HEIGHT)
            height_reg = data;
    endtask

    task automatic write_sizes(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_put(REG_GRID_WIDTH, w);
        if ($urandom_range(0, 3) == 0)
            cfg_put($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
        cfg_put(REG_GRID_HEIGHT, h);
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_used++;
        if (size_used(w, MAX_WIDTH) > widest)
            widest = size_used(w, MAX_WIDTH);
    endtask

    // Holds the sender back until every predicted result has been delivered,
    // then waits on while the block finishes its silent work.
    task automatic settle();
        while (cell_queue.size() != 0 || cell_ch.valid || due_results.size() != 0)
            @(negedge clk);
        repeat (size_used(width_reg, MAX_WIDTH) + 4)
            @(negedge clk);
    endtask

    function automatic cell_t random_cell();
        cell_t       c;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            c.temp = TEMP_ZERO;
        else if (roll < 20)
            c.temp = TEMP_ONE;
        else if (roll < 35)
            c.temp = TEMP_W'($urandom);
        else
            c.temp = TEMP_W'($urandom_range(0, 32768));
        c.source = ($urandom_range(0, 99) < 15);
        c.flush  = 1'b0;
        return c;
    endfunction

    // Grid cells in raster order, with the odd stray flush that must be dropped.
    task automatic push_cells(input int unsigned n);
        cell_t c;
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                c       = random_cell();
                c.flush = 1'b1;
                cell_queue.push_back(c);
            end
            cell_queue.push_back(random_cell());
            stimulus_items++;
        end
    endtask

    // The drain row; its payload is meaningless, so it is random. Sometimes a
    // late grid cell goes first, which the block must ignore.
    task automatic push_flush(input int unsigned n);
        cell_t c;
        if ($urandom_range(0, 4) == 0)
            cell_queue.push_back(random_cell());
        for (int unsigned i = 0; i < n; i++)
        begin
            c       = random_cell();
            c.flush = 1'b1;
            cell_queue.push_back(c);
            stimulus_items++;
        end
    endtask

    task automatic push_grid(input int unsigned w, input int unsigned h);
        push_cells(w * h);
        push_flush(w);
    endtask

    // Queues what a grid still needs after its sizes were shrunk part-way
    // through: the rest of the rows under the new sizes, then the drain row
    // from wherever the column counter stands.
    task automatic finish_grid();
        int unsigned nw;
        int unsigned nh;
        int unsigned rest_cells;
        int unsigned rest_flush;
        nw = size_used(width_reg, MAX_WIDTH);
        nh = size_used(height_reg, MAX_HEIGHT);
        if (row_pos < nh)
        begin
            rest_cells = (col_pos >= nw - 1) ? 1 : nw - col_pos;
            rest_cells += (nh - 1 - row_pos) * nw;
            rest_flush = nw;
        end
        else
        begin
            rest_cells = 0;
            rest_flush = (col_pos >= nw - 1) ? 1 : nw - col_pos;
        end
        push_cells(rest_cells);
        push_flush(rest_flush);
    endtask

    // Shrinks the grid part-way through: the block keeps its position, treats
    // a column past the new end as border and a row past the new height as the
    // start of the drain. Growing is never done, as it would read buffer
    // columns this grid has not filled.
    task automatic resize_mid_grid();
        int unsigned w;
        int unsigned h;
        int unsigned nw;
        int unsigned nh;
        w = $urandom_range(4, 12);
        h = $urandom_range(3, 8);
        settle();
        write_sizes(CFG_W'(w), CFG_W'(h));
        push_cells($urandom_range(1, w * h - 1));
        settle();
        nw = $urandom_range(1, w);
        nh = $urandom_range(1, h);
        write_sizes(CFG_W'(nw), CFG_W'(nh));
        finish_grid();
    endtask

    initial
    begin : stimulus
        logic [CFG_W-1:0] raw_w;
        logic [CFG_W-1:0] raw_h;
        cell_t            c;

        cfg_write                = 1'b0;
        cfg_index                = '0;
        cfg_data                 = '0;
        width_reg                = GRID_WIDTH_RESET;
        height_reg               = GRID_HEIGHT_RESET;
        col_pos                  = 0;
        row_pos                  = 0;
        calm                     = 1'b0;
        failures                 = 0;
        cells_taken              = 0;
        results_seen             = 0;
        grids_seen               = 0;
        settings_used            = 0;
        stimulus_items           = 0;
        widest                   = 0;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed grid. The spare indexes are written with all ones and all
        // zeros first; neither may disturb the sizes that follow.
        cfg_put(REG_SPARE_A, '1);
        cfg_put(REG_SPARE_B, '0);
        write_sizes(CFG_W'(4), CFG_W'(4));
        for (int unsigned i = 0; i < 16; i++)
        begin
            c = '{temp: DEMO_TEMP[i], source: DEMO_SOURCE[i], flush: 1'b0};
            cell_queue.push_back(c);
            // A flush in the middle of the grid must be ignored.
            if (i == 5)
                cell_queue.push_back(cell_t'{temp: 16'hFFFF, source: 1'b1, flush: 1'b1});
        end
        // A grid cell after the last row is ignored until the drain completes.
        cell_queue.push_back(cell_t'{temp: 16'h1234, source: 1'b1, flush: 1'b0});
        for (int unsigned i = 0; i < 4; i++)
            cell_queue.push_back(cell_t'{temp: 16'hFFFF, source: 1'b1, flush: 1'b1});

        // Random grids, mostly small so that the borders, the interior and the
        // drain all get plenty of transfers; now and then a wider row.
        stimulus_items = 0;
        while (stimulus_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                resize_mid_grid();
            else
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    settle();
                    raw_w = ($urandom_range(0, 5) == 0) ? CFG_W'($urandom_range(11, 40))
                                                        : CFG_W'($urandom_range(0, 10));
                    raw_h = CFG_W'($urandom_range(0, 8));
                    write_sizes(raw_w, raw_h);
                end
                calm = ($urandom_range(0, 4) == 0);
                push_grid(size_used(width_reg, MAX_WIDTH), size_used(height_reg, MAX_HEIGHT));
            end
        end

        // Size extremes: both registers at their largest value, clamped to the
        // buffer depth, then shrunk part-way through the first row so the grid
        // stays short; and the smallest grid via zeros.
        calm = 1'b0;
        settle();
        write_sizes('1, '1);
        push_cells(50);
        settle();
        write_sizes(CFG_W'(6), CFG_W'(3));
        finish_grid();
        settle();
        write_sizes('0, '0);
        push_grid(1, 1);

        while (cell_queue.size() != 0 || cell_ch.valid || due_results.size() != 0)
            @(negedge clk);
        // Anything arriving now has no prediction behind it and is flagged.
        repeat (32) @(negedge clk);

        $display("Covered %0d cell transfers and %0d results over %0d complete grids,",
                 cells_taken, results_seen, grids_seen);
        $display("using %0d size settings with row sizes of 1 to %0d cells.",
                 settings_used, widest);
        if (failures == 0 && due_results.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d failures recorded", failures);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
hdl/hds_pkg.sv
hdl/hds_channels.sv
hdl/hds_line_buffer.sv
hdl/heat_diffusion_stencil_step_unit.sv
dv/tb_heat_diffusion_stencil_step_unit.sv
